// ===== rtl/core/spt_pkg.sv =====
// Shared types and constants for the sequential pulse-train generator.
// No dependencies.
`default_nettype none
package spt_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int TICKS_PER_MS = 1000;

  localparam int CH_W    = 3;
  localparam int WIDTH_W = 16;
  localparam int PINS_W  = 8;
  localparam int MS_W    = 16;
  localparam int LRMS_W  = 10;
  localparam int PRE_W   = $clog2(TICKS_PER_MS + 1);
  localparam int ADDR_W  = 4;

  localparam logic [WIDTH_W-1:0] GAP_RESET    = 16'd100;
  localparam logic [LRMS_W-1:0]  LOWRATE_RESET = 10'd20;

  // item opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // register word indexes
  localparam logic [1:0] REG_MASK    = 2'd0;
  localparam logic [1:0] REG_GAP     = 2'd1;
  localparam logic [1:0] REG_LOWRATE = 2'd2;

  typedef struct packed {
    logic [PINS_W-1:0]  high_rate_mask;
    logic [WIDTH_W-1:0] gap_ticks;
    logic [LRMS_W-1:0]  low_rate_ms;
  } cfg_t;

  typedef struct packed {
    logic               en;
    logic [CH_W-1:0]    addr;
    logic [WIDTH_W-1:0] data;
  } wr_t;

  typedef struct packed {
    logic [PINS_W-1:0] pins;
    logic              slot_start;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/spt_width_mem.sv =====
// Per-channel width store: synchronous memory with a registered read.
// Write-first on a same-address collision; unwritten entries read as zero. Uses spt_pkg.
`default_nettype none
module spt_width_mem
  import spt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire wr_t                wr_i,
  input  wire logic [CH_W-1:0]    rd_addr_i,
  output logic      [WIDTH_W-1:0] rd_data_o
);

  logic [WIDTH_W-1:0]      mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld_q;
  logic [WIDTH_W-1:0]      rd_q;
  logic                    rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (wr_i.en && (wr_i.addr == rd_addr_i)) begin
      rd_q <= wr_i.data;
    end else begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      rd_vld_q <= (wr_i.en && (wr_i.addr == rd_addr_i)) || vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule
`default_nettype wire

// ===== rtl/core/spt_cfg.sv =====
// APB register file: high-rate mask, gap length, low-rate window period.
// Uses spt_pkg.
`default_nettype none
module spt_cfg
  import spt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_rate_mask <= '0;
      cfg_q.gap_ticks      <= GAP_RESET;
      cfg_q.low_rate_ms    <= LOWRATE_RESET;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_MASK:    cfg_q.high_rate_mask <= pwdata[PINS_W-1:0];
        REG_GAP:     cfg_q.gap_ticks      <= pwdata[WIDTH_W-1:0];
        REG_LOWRATE: cfg_q.low_rate_ms    <= pwdata[LRMS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MASK:    prdata = 32'(cfg_q.high_rate_mask);
      REG_GAP:     prdata = 32'(cfg_q.gap_ticks);
      REG_LOWRATE: prdata = 32'(cfg_q.low_rate_ms);
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/core/spt_slot_ctrl.sv =====
// Slot sequencer: countdown, channel pointer, millisecond time and window decision.
// Prefetches the next channel's width from spt_width_mem. Uses spt_pkg.
`default_nettype none
module spt_slot_ctrl
  import spt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               take_i,
  input  wire logic               op_i,
  input  wire logic [CH_W-1:0]    channel_i,
  input  wire logic [WIDTH_W-1:0] width_us_i,
  input  wire cfg_t               cfg_i,
  input  wire logic [WIDTH_W-1:0] width_rd_i,
  output wr_t                     wr_o,
  output logic      [CH_W-1:0]    rd_addr_o,
  output result_t                 res_o
);

  logic [CH_W-1:0]    slot_q, slot_d;
  logic [WIDTH_W-1:0] cnt_q, cnt_d;
  logic [PRE_W-1:0]   pre_q, pre_d;
  logic [MS_W-1:0]    ms_q, ms_d;
  logic [MS_W-1:0]    last_q, last_d;
  logic               win_q, win_d;
  logic [PINS_W-1:0]  pin_q, pin_d;

  logic               tick;
  logic [WIDTH_W-1:0] cnt_dec;
  logic               start;
  logic [MS_W-1:0]    elapsed;
  logic               open_new;
  logic               window;
  logic               pulse;
  logic [PRE_W-1:0]   pre_inc;

  assign tick = take_i && (op_i == OP_TICK);

  assign wr_o.en   = take_i && (op_i == OP_WRITE) &&
                     ({1'b0, channel_i} < (CH_W+1)'(NUM_CHANNELS));
  assign wr_o.addr = channel_i;
  assign wr_o.data = width_us_i;

  assign cnt_dec  = cnt_q - WIDTH_W'(cnt_q != '0);
  assign start    = (cnt_dec == '0);
  assign elapsed  = ms_q - last_q;
  assign open_new = elapsed > MS_W'(cfg_i.low_rate_ms);
  assign window   = (slot_q == '0) ? open_new : win_q;
  // width_rd_i already holds the current channel's width
  assign pulse    = (width_rd_i != '0) && (cfg_i.high_rate_mask[slot_q] || window);
  assign pre_inc  = pre_q + PRE_W'(1);

  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    pre_d  = pre_q;
    ms_d   = ms_q;
    last_d = last_q;
    win_d  = win_q;
    pin_d  = pin_q;
    if (tick) begin
      cnt_d = cnt_dec;
      if (start) begin
        if (slot_q == '0) begin
          win_d = open_new;
          if (open_new) begin
            last_d = ms_q;
          end
        end
        if (pulse) begin
          pin_d = PINS_W'(1) << slot_q;
          cnt_d = width_rd_i;
        end else begin
          pin_d = '0;
          cnt_d = cfg_i.gap_ticks;
        end
        if (slot_q == CH_W'(NUM_CHANNELS - 1)) begin
          slot_d = '0;
        end else begin
          slot_d = slot_q + CH_W'(1);
        end
      end
      if (pre_inc >= PRE_W'(TICKS_PER_MS)) begin
        pre_d = '0;
        ms_d  = ms_q + MS_W'(1);
      end else begin
        pre_d = pre_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      cnt_q  <= '0;
      pre_q  <= '0;
      ms_q   <= '0;
      last_q <= '0;
      win_q  <= 1'b0;
      pin_q  <= '0;
    end else begin
      slot_q <= slot_d;
      cnt_q  <= cnt_d;
      pre_q  <= pre_d;
      ms_q   <= ms_d;
      last_q <= last_d;
      win_q  <= win_d;
      pin_q  <= pin_d;
    end
  end

  assign rd_addr_o      = slot_d;
  assign res_o.pins       = pin_d;
  assign res_o.slot_start = tick && start;

endmodule
`default_nettype wire

// ===== rtl/core/spt_out_buf.sv =====
// Output register with skid stage; decouples input stall from output stall.
// Uses spt_pkg.
`default_nettype none
module spt_out_buf
  import spt_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t data_i,
  output logic         full_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output result_t      out_data_o
);

  logic    out_valid_q;
  logic    skid_valid_q;
  result_t out_data_q;
  result_t skid_data_q;
  logic    out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : data_i;
    end else if (push_i) begin
      skid_data_q <= data_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

// ===== rtl/core/sequential_pulse_train_generator.sv =====
// Sequential pulse-train generator, eight channels.
// Output: a result enters the output register, or the skid stage while the output stalls.
// Throughput: one item per cycle while in_stall_o is low; the next channel's width is
// prefetched from the width memory so a slot start never waits on the registered read.
// Reset: asynchronous, active low; all widths read as zero, pins low, first tick
// starts a slot; registers return to mask 0, gap 100, window 20 ms.
`default_nettype none
module sequential_pulse_train_generator
  import spt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               op_i,
  input  wire logic [CH_W-1:0]    channel_i,
  input  wire logic [WIDTH_W-1:0] width_us_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [PINS_W-1:0]  pins_o,
  output logic                    slot_start_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  cfg_t               cfg;
  wr_t                wr;
  logic [CH_W-1:0]    rd_addr;
  logic [WIDTH_W-1:0] width_rd;
  result_t            res;
  result_t            out_data;
  logic               full;
  logic               take;

  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  spt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  spt_width_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (width_rd)
  );

  spt_slot_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .op_i       (op_i),
    .channel_i  (channel_i),
    .width_us_i (width_us_i),
    .cfg_i      (cfg),
    .width_rd_i (width_rd),
    .wr_o       (wr),
    .rd_addr_o  (rd_addr),
    .res_o      (res)
  );

  spt_out_buf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (take),
    .data_i      (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign pins_o       = out_data.pins;
  assign slot_start_o = out_data.slot_start;

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for sequential_pulse_train_generator: tick and width-write items go in,
// pin and slot-start outputs are predicted and compared transfer by transfer.
// Depends on spt_pkg and the generator RTL only.
module testbench;
  import spt_pkg::*;

  // Predicts the pin state for every accepted item and holds the outputs still owed.
  class pulse_train_tracker;
    logic [WIDTH_W-1:0] chan_width [NUM_CHANNELS];
    logic [CH_W-1:0]    next_chan;
    logic [WIDTH_W-1:0] countdown;
    int unsigned        prescale;
    logic [MS_W-1:0]    ms_now;
    logic [MS_W-1:0]    window_start;
    bit                 window_open;
    logic [PINS_W-1:0]  pin_drive;
    logic [PINS_W-1:0]  rate_mask;
    logic [WIDTH_W-1:0] gap_len;
    logic [LRMS_W-1:0]  low_rate;
    result_t            owed_q[$];
    int                 errors;

    function new();
      foreach (chan_width[i]) chan_width[i] = '0;
      next_chan    = '0;
      countdown    = '0;
      prescale     = 0;
      ms_now       = '0;
      window_start = '0;
      window_open  = 1'b0;
      pin_drive    = '0;
      rate_mask    = '0;
      gap_len      = GAP_RESET;
      low_rate     = LOWRATE_RESET;
      errors       = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_MASK:    rate_mask = value[PINS_W-1:0];
        REG_GAP:     gap_len   = value[WIDTH_W-1:0];
        REG_LOWRATE: low_rate  = value[LRMS_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_item(logic op, logic [CH_W-1:0] ch, logic [WIDTH_W-1:0] w);
      result_t         r;
      logic [MS_W-1:0] elapsed;
      r.slot_start = 1'b0;
      if (op == OP_WRITE) begin
        if (int'(ch) < NUM_CHANNELS) chan_width[ch] = w;
      end else begin
        if (countdown != 0) countdown = countdown - 1'b1;
        if (countdown == 0) begin
          pin_drive = '0;
          // window is decided on the millisecond count before this tick advances it
          if (next_chan == 0) begin
            elapsed     = ms_now - window_start;
            window_open = (elapsed > MS_W'(low_rate));
            if (window_open) window_start = ms_now;
          end
          if (chan_width[next_chan] != 0 && (rate_mask[next_chan] || window_open)) begin
            pin_drive = PINS_W'(1) << next_chan;
            countdown = chan_width[next_chan];
          end else begin
            countdown = gap_len;
          end
          if (int'(next_chan) + 1 >= NUM_CHANNELS) next_chan = '0;
          else next_chan = next_chan + 1'b1;
          r.slot_start = 1'b1;
        end
        prescale++;
        if (prescale >= TICKS_PER_MS) begin
          prescale = 0;
          ms_now   = ms_now + 1'b1;
        end
      end
      r.pins = pin_drive;
      owed_q.push_back(r);
    endfunction

    function void check_output(logic [PINS_W-1:0] pins, logic slot_start);
      result_t want;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: output with none owed, pins %h slot_start %b", $time, pins, slot_start);
        return;
      end
      want = owed_q.pop_front();
      if (pins !== want.pins) begin
        errors++;
        $display("%0t: pins expected %h got %h", $time, want.pins, pins);
      end
      if (slot_start !== want.slot_start) begin
        errors++;
        $display("%0t: slot_start expected %b got %b", $time, want.slot_start, slot_start);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic               op_i        = OP_TICK;
  logic [CH_W-1:0]    channel_i   = '0;
  logic [WIDTH_W-1:0] width_us_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [PINS_W-1:0]  pins_o;
  logic               slot_start_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [ADDR_W-1:0]  paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;

  pulse_train_tracker tracker;
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_idle_pct = 0;

  sequential_pulse_train_generator uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .channel_i    (channel_i),
    .width_us_i   (width_us_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pins_o       (pins_o),
    .slot_start_o (slot_start_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // transfers on both channels, seen at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) tracker.take_item(op_i, channel_i, width_us_i);
      if (out_valid_o && !out_stall_i) tracker.check_output(pins_o, slot_start_o);
    end
  end

  // called on a falling edge, returns on a falling edge
  task automatic send_item(logic op, logic [CH_W-1:0] ch, logic [WIDTH_W-1:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    channel_i  <= ch;
    width_us_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reg(idx, value);
  endtask

  task automatic configure(logic [PINS_W-1:0] mask, logic [WIDTH_W-1:0] gap,
                           logic [LRMS_W-1:0] low_ms);
    reg_write(REG_MASK, 32'(mask));
    reg_write(REG_GAP, 32'(gap));
    reg_write(REG_LOWRATE, 32'(low_ms));
  endtask

  // drop valid and let every owed output drain, plus the output register stage
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.owed_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic random_item();
    int unsigned     pick;
    logic [CH_W-1:0] ch;
    pick = $urandom_range(99);
    ch   = CH_W'($urandom_range(NUM_CHANNELS - 1));
    if (pick < 80) begin
      // channel and width are don't-care on a tick; randomise them anyway
      send_item(OP_TICK, CH_W'($urandom), WIDTH_W'($urandom));
    end else if (pick < 83) begin
      send_item(OP_WRITE, ch, '0);
    end else if (pick < 93) begin
      send_item(OP_WRITE, ch, WIDTH_W'($urandom_range(12, 1)));
    end else if (pick < 97) begin
      send_item(OP_WRITE, ch, WIDTH_W'($urandom_range(300, 13)));
    end else begin
      // full-range width, overwritten before any tick could load it
      send_item(OP_WRITE, ch, WIDTH_W'($urandom));
      send_item(OP_WRITE, ch, WIDTH_W'($urandom_range(12, 1)));
    end
  endtask

  initial begin
    logic [PINS_W-1:0]  mask;
    logic [WIDTH_W-1:0] gap;
    logic [LRMS_W-1:0]  low_ms;
    tracker = new();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    configure(8'hFF, 16'd0, 10'd1000);
    send_item(OP_TICK, 3'd0, 16'd0);
    send_item(OP_WRITE, 3'd0, 16'hFFFF);
    send_item(OP_WRITE, 3'd0, 16'd3);
    send_item(OP_WRITE, 3'd7, 16'hFFFF);
    send_item(OP_WRITE, 3'd7, 16'd2);
    send_item(OP_WRITE, 3'd1, 16'd1);
    send_item(OP_WRITE, 3'd2, 16'd0);
    repeat (16) send_item(OP_TICK, 3'd7, 16'hFFFF);
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0:       begin send_idle_pct = 38; recv_idle_pct = 72; end
        1:       begin send_idle_pct = 72; recv_idle_pct = 38; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      case (phase)
        0: begin
          mask = 8'h55;  gap = 16'd1;  low_ms = 10'd0;
        end
        1: begin
          mask   = PINS_W'($urandom);
          gap    = WIDTH_W'($urandom_range(40, 1));
          low_ms = 10'd0;
        end
        2: begin
          mask = 8'hFF;  gap = 16'd3;  low_ms = 10'd1000;
        end
        3: begin
          mask   = 8'h00;
          gap    = WIDTH_W'($urandom_range(16, 1));
          low_ms = 10'd0;
        end
        4: begin
          mask   = PINS_W'($urandom);
          gap    = 16'd0;
          low_ms = LRMS_W'($urandom_range(1000));
        end
        default: begin
          mask   = PINS_W'($urandom);
          gap    = 16'hFFFF;
          low_ms = 10'd0;
        end
      endcase
      configure(mask, gap, low_ms);
      repeat (275) random_item();
      settle();
    end

    if (tracker.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/spt_pkg.sv
rtl/core/spt_width_mem.sv
rtl/core/spt_cfg.sv
rtl/core/spt_slot_ctrl.sv
rtl/core/spt_out_buf.sv
rtl/core/sequential_pulse_train_generator.sv
dv/testbench.sv
